>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
// No dependencies; include this header by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the reset is asserted.
`define LCFS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("lcfs: clocked assertion failed");

// Clocked assertion that is also checked while the reset is asserted.
`define LCFS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lcfs: reset-time assertion failed");

`endif

>>> hw/rtl/lcfs_pkg.sv
// Package of the LFO driven crossfade selector: constants, beat types, helpers.
// No dependencies; every other file of the block but lcfs_fifo and the macro header imports it.
package lcfs_pkg;

  // Block dimensions.
  localparam int unsigned NumSlots   = 8;
  localparam int unsigned SampleBits = 16;
  localparam int unsigned EntW       = $clog2(NumSlots);
  localparam int unsigned CntW       = $clog2(NumSlots + 1);
  localparam int unsigned QueueDepth = 2;

  // Q16 position and LFO mapping.
  localparam int unsigned PosW       = 17;
  localparam int unsigned WideW      = (SampleBits >= 16) ? SampleBits + 1 : 17;
  localparam int unsigned LfoFracW   = 15;
  localparam int unsigned RecipW     = 24;
  localparam logic [RecipW-1:0] RecipM = 24'd8589935;  // ceil(2^30 / 125)
  localparam int unsigned RecipShift = 22;
  localparam logic [WideW-1:0] LfoOffset = WideW'(16000);
  localparam logic [WideW-1:0] LfoSpan   = WideW'(32000);
  localparam logic [PosW-1:0] QOne      = 17'h10000;
  localparam logic [PosW-1:0] EdgeLow   = 17'd6;
  localparam logic [PosW-1:0] EdgeHigh  = 17'd65530;

  // Random stepping.
  localparam logic [31:0] LfsrTaps = 32'h8020_0003;
  localparam logic [31:0] LfsrSeed = 32'hACE1_ACE1;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 2;
  localparam logic [CfgIdxW-1:0] CfgCvRange = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgVoid    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgReverse = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgRandom  = 2'd3;

  // Range mode codes.
  localparam logic [1:0] CvBipolar = 2'd0;
  localparam logic [1:0] CvScanAll = 2'd2;

  typedef struct packed {
    logic [1:0] cv_range_mode;
    logic       void_mode;
    logic       reverse_mode;
    logic       random_mode;
  } cfg_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] sample_0;
    logic signed [SampleBits-1:0] sample_1;
    logic signed [SampleBits-1:0] sample_2;
    logic signed [SampleBits-1:0] sample_3;
    logic signed [SampleBits-1:0] sample_4;
    logic signed [SampleBits-1:0] sample_5;
    logic signed [SampleBits-1:0] sample_6;
    logic signed [SampleBits-1:0] sample_7;
    logic signed [SampleBits-1:0] lfo_sample;
    logic [NumSlots-1:0]          connected_mask;
  } in_beat_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] mix_out;
    logic [EntW-1:0]              current_slot;
    logic [EntW-1:0]              next_slot;
    logic [PosW-1:0]              current_weight;
    logic                         crossed;
    logic                         active;
  } out_beat_t;

  typedef logic [NumSlots-1:0][SampleBits-1:0] smp_vec_t;
  typedef logic [NumSlots-1:0][EntW-1:0]       list_vec_t;

  // One classified item as handed from the front end to the back end.
  typedef struct packed {
    smp_vec_t        smp;
    list_vec_t       list;
    logic [CntW-1:0] n;
    logic            regular;
    logic            lo_ext;
    logic            hi_ext;
    logic [PosW-1:0] pos;
    logic [EntW-1:0] scan_cur;
    logic [EntW-1:0] scan_nxt;
    logic [PosW-1:0] scan_w;
  } work_t;

  // One step of the Galois LFSR, shifting right.
  function automatic logic [31:0] lfsr_step(input logic [31:0] x);
    logic [31:0] s;
    s = {1'b0, x[31:1]};
    return x[0] ? (s ^ LfsrTaps) : s;
  endfunction

endpackage

>>> hw/rtl/lcfs_fifo.sv
// Small first-word-fall-through queue used between the stages of the selector.
// Depends on nothing but its type and depth parameters.
module lcfs_fifo #(
  parameter type         T     = logic,
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned FillW = $clog2(Depth + 1);

  T                 mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FillW-1:0] fill_q;
  logic             do_push, do_pop;

  assign full_o  = (fill_q == FillW'(Depth));
  assign empty_o = (fill_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  // Storage of the waiting beats.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> hw/rtl/lcfs_modu.sv
// Iterative remainder unit: 32-bit dividend modulo a small divisor, 8 bits a cycle.
// Depends on lcfs_pkg for the divisor width.
module lcfs_modu (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [31:0]               dividend_i,
  input  logic [lcfs_pkg::CntW-1:0] divisor_i,
  output logic                      done_o,
  output logic [lcfs_pkg::CntW-1:0] rem_o
);
  import lcfs_pkg::*;

  localparam int unsigned DvdW     = 32;
  localparam int unsigned StepBits = 8;
  localparam int unsigned NumSteps = DvdW / StepBits;
  localparam int unsigned StepCntW = $clog2(NumSteps);

  logic                busy_q, done_q;
  logic [StepCntW-1:0] step_q;
  logic [DvdW-1:0]     dvd_q;
  logic [CntW-1:0]     dsr_q, rem_q, rem_nx;

  assign done_o = done_q;
  assign rem_o  = rem_q;

  // Eight restoring remainder steps on the top bits of the dividend.
  always_comb begin
    logic [CntW:0]   t;
    logic [CntW-1:0] r;
    r = rem_q;
    for (int k = 0; k < StepBits; k++) begin
      t = {r, dvd_q[DvdW-1-k]};
      if (t >= {1'b0, dsr_q}) begin
        t = t - {1'b0, dsr_q};
      end
      r = t[CntW-1:0];
    end
    rem_nx = r;
  end

  // Control of the iteration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == StepCntW'(NumSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Dividend, divisor and partial remainder.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << StepBits;
      rem_q <= rem_nx;
    end
  end

endmodule

>>> hw/rtl/lcfs_front.sv
// Front end: accepts input beats, builds the slot list and the Q16 LFO position.
// Depends on lcfs_pkg; feeds the work queue in front of the back end.
module lcfs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lcfs_pkg::cfg_t      cfg_i,
  input  logic                push_i,
  input  lcfs_pkg::in_beat_t  beat_i,
  output logic                full_o,
  output logic                work_valid_o,
  output lcfs_pkg::work_t     work_o,
  input  logic                work_ready_i
);
  import lcfs_pkg::*;

  localparam int unsigned ProdW = LfoFracW + RecipW;
  localparam int unsigned QW    = PosW + CntW;

  typedef struct packed {
    smp_vec_t        smp;
    list_vec_t       list;
    logic [CntW-1:0] n;
    logic            regular;
    logic            p_zero;
    logic            p_full;
    logic [15:0]     p_frac;
  } stage_b_t;

  logic     a_valid_q, b_valid_q;
  in_beat_t a_beat_q;
  stage_b_t b_q, b_d;
  logic     a_load, b_adv, work_push;

  // Two-stage pipeline that holds while the work queue is full.
  assign work_push    = b_valid_q && work_ready_i;
  assign b_adv        = !b_valid_q || work_push;
  assign full_o       = a_valid_q && !b_adv;
  assign a_load       = push_i && !full_o;
  assign work_valid_o = b_valid_q;

  // First stage: slot list, count and the scaled LFO product.
  always_comb begin
    logic [NumSlots-1:0]    used;
    logic [CntW-1:0]        cnt;
    logic signed [WideW-1:0] v;
    logic [ProdW-1:0]       prod;
    b_d.smp[0] = a_beat_q.sample_0;
    b_d.smp[1] = a_beat_q.sample_1;
    b_d.smp[2] = a_beat_q.sample_2;
    b_d.smp[3] = a_beat_q.sample_3;
    b_d.smp[4] = a_beat_q.sample_4;
    b_d.smp[5] = a_beat_q.sample_5;
    b_d.smp[6] = a_beat_q.sample_6;
    b_d.smp[7] = a_beat_q.sample_7;
    used = cfg_i.void_mode ? '1 : a_beat_q.connected_mask;
    b_d.list = '0;
    cnt = '0;
    for (int i = 0; i < NumSlots; i++) begin
      if (used[i]) begin
        b_d.list[cnt[EntW-1:0]] = EntW'(i);
      end
      cnt = cnt + CntW'(used[i]);
    end
    b_d.n = cnt;
    b_d.regular = (cfg_i.cv_range_mode < CvScanAll);
    v = {{(WideW - SampleBits){a_beat_q.lfo_sample[SampleBits-1]}}, a_beat_q.lfo_sample};
    if (cfg_i.cv_range_mode == CvBipolar) begin
      v = v + $signed(LfoOffset);
    end
    b_d.p_zero = v[WideW-1] || (v == '0);
    b_d.p_full = !v[WideW-1] && ($unsigned(v) >= LfoSpan);
    prod = ProdW'(v[LfoFracW-1:0]) * ProdW'(RecipM);
    b_d.p_frac = prod[RecipShift +: 16];
  end

  // Second stage: position, extremes and the scan-all pair and weight.
  always_comb begin
    logic [PosW-1:0] p;
    logic [QW-1:0]   q;
    logic [CntW:0]   raw, raw_inc;
    p = b_q.p_zero ? '0 : (b_q.p_full ? QOne : {1'b0, b_q.p_frac});
    q = QW'(p) * QW'(b_q.n);
    raw = q[QW-1:16];
    raw_inc = raw + 1'b1;
    work_o.smp      = b_q.smp;
    work_o.list     = b_q.list;
    work_o.n        = b_q.n;
    work_o.regular  = b_q.regular;
    work_o.pos      = p;
    work_o.lo_ext   = (p <= EdgeLow);
    work_o.hi_ext   = (p >= EdgeHigh);
    work_o.scan_cur = (raw >= {1'b0, b_q.n}) ? '0 : raw[EntW-1:0];
    work_o.scan_nxt = (raw_inc >= {1'b0, b_q.n}) ? '0 : raw_inc[EntW-1:0];
    work_o.scan_w   = QOne - {1'b0, q[15:0]};
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_load || (a_valid_q && !b_adv);
      if (b_adv) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (a_load) begin
      a_beat_q <= beat_i;
    end
    if (b_adv && a_valid_q) begin
      b_q <= b_d;
    end
  end

endmodule

>>> hw/rtl/lcfs_back.sv
// Back end: sequencer that keeps the entry state, picks next entries and mixes.
// Depends on lcfs_pkg and lcfs_modu; reads the work queue, writes the result queue.
module lcfs_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lcfs_pkg::cfg_t       cfg_i,
  input  logic                 work_valid_i,
  input  lcfs_pkg::work_t      work_i,
  output logic                 work_pop_o,
  input  logic                 out_full_i,
  output logic                 out_push_o,
  output lcfs_pkg::out_beat_t  out_beat_o
);
  import lcfs_pkg::*;

  localparam int unsigned ProdW = PosW + 1 + SampleBits;
  localparam int unsigned SumW  = ProdW + 1;
  localparam int unsigned ShW   = SumW - 16;
  localparam logic signed [ShW-1:0] MixMax = ShW'((1 << (SampleBits - 1)) - 1);
  localparam logic signed [ShW-1:0] MixMin = ~MixMax;

  // Sequencer states.
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPrep = 3'd1;
  localparam logic [2:0] StPick = 3'd2;
  localparam logic [2:0] StModw = 3'd3;
  localparam logic [2:0] StMul  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0]              st_q, st_d;
  work_t                   item_q, item_d;
  logic [EntW-1:0]         cur_q, cur_d, nxt_q, nxt_d;
  logic                    fall_q, fall_d, second_q, second_d, crossed_q, crossed_d;
  logic [31:0]             lfsr_q, lfsr_d, lfsr_nx;
  logic [PosW-1:0]         w_q, w_d, w_sel;
  logic [EntW-1:0]         cs_q, cs_d, ns_q, ns_d, pick_step;
  logic signed [ProdW-1:0] pa_q, pa_d, pb_q, pb_d;
  logic [CntW-1:0]         nm1, mod_rem;
  logic                    n_zero, mod_start, mod_done, extreme;

  assign n_zero  = (item_q.n == '0);
  assign nm1     = item_q.n - 1'b1;
  assign lfsr_nx = lfsr_step(lfsr_q);
  assign extreme = item_q.regular && (fall_q ? item_q.hi_ext : item_q.lo_ext);

  // Shared remainder unit for random picks.
  lcfs_modu u_modu (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (lfsr_nx),
    .divisor_i  (nm1),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // Forward or backward step to the neighboring list entry.
  always_comb begin
    if (cfg_i.reverse_mode) begin
      pick_step = (cur_q == '0) ? nm1[EntW-1:0] : EntW'(cur_q - 1'b1);
    end else begin
      pick_step = ((CntW'(cur_q) + 1'b1) == item_q.n) ? '0 : EntW'(cur_q + 1'b1);
    end
  end

  // Weight of the current entry.
  always_comb begin
    if (!item_q.regular) begin
      w_sel = item_q.scan_w;
    end else begin
      w_sel = fall_q ? (QOne - item_q.pos) : item_q.pos;
    end
  end

  // Rounding, scaling and saturation of the mix.
  always_comb begin
    logic signed [SumW-1:0] s;
    logic signed [ShW-1:0]  sh;
    s = $signed({pa_q[ProdW-1], pa_q}) + $signed({pb_q[ProdW-1], pb_q})
        + $signed(SumW'(32768));
    sh = s[SumW-1:16];
    if (sh > MixMax) begin
      sh = MixMax;
    end else if (sh < MixMin) begin
      sh = MixMin;
    end
    out_beat_o.mix_out        = sh[SampleBits-1:0];
    out_beat_o.current_slot   = cs_q;
    out_beat_o.next_slot      = ns_q;
    out_beat_o.current_weight = w_q;
    out_beat_o.crossed        = crossed_q;
    out_beat_o.active         = !n_zero;
  end

  // Sequencer.
  always_comb begin
    st_d       = st_q;
    item_d     = item_q;
    cur_d      = cur_q;
    nxt_d      = nxt_q;
    fall_d     = fall_q;
    lfsr_d     = lfsr_q;
    second_d   = second_q;
    crossed_d  = crossed_q;
    w_d        = w_q;
    cs_d       = cs_q;
    ns_d       = ns_q;
    pa_d       = pa_q;
    pb_d       = pb_q;
    work_pop_o = 1'b0;
    out_push_o = 1'b0;
    mod_start  = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (work_valid_i) begin
          item_d     = work_i;
          work_pop_o = 1'b1;
          st_d       = StPrep;
        end
      end
      // Bring the entries into the current list, or take the scan pair.
      StPrep: begin
        crossed_d = 1'b0;
        second_d  = 1'b0;
        st_d      = StMul;
        if (!n_zero) begin
          if (item_q.regular) begin
            if (CntW'(cur_q) >= item_q.n) begin
              cur_d = '0;
            end
            if (CntW'(nxt_q) >= item_q.n) begin
              st_d = StPick;
            end
          end else begin
            cur_d = item_q.scan_cur;
            nxt_d = item_q.scan_nxt;
          end
        end
      end
      // Choose a new next entry.
      StPick: begin
        if (item_q.n <= CntW'(1)) begin
          nxt_d = '0;
          st_d  = second_q ? StOut : StMul;
        end else if (cfg_i.random_mode) begin
          lfsr_d    = lfsr_nx;
          mod_start = 1'b1;
          st_d      = StModw;
        end else begin
          nxt_d = pick_step;
          st_d  = second_q ? StOut : StMul;
        end
      end
      // Random draw; the current entry is never drawn.
      StModw: begin
        if (mod_done) begin
          nxt_d = (mod_rem == CntW'(cur_q)) ? nm1[EntW-1:0] : mod_rem[EntW-1:0];
          st_d  = second_q ? StOut : StMul;
        end
      end
      // Products of the weights and samples, then the advance at an extreme.
      StMul: begin
        if (n_zero) begin
          w_d  = '0;
          cs_d = '0;
          ns_d = '0;
          pa_d = '0;
          pb_d = '0;
        end else begin
          w_d  = w_sel;
          cs_d = item_q.list[cur_q];
          ns_d = item_q.list[nxt_q];
          pa_d = $signed({1'b0, w_sel}) * $signed(item_q.smp[item_q.list[cur_q]]);
          pb_d = $signed({1'b0, QOne - w_sel}) * $signed(item_q.smp[item_q.list[nxt_q]]);
        end
        if (extreme) begin
          fall_d    = !fall_q;
          cur_d     = nxt_q;
          crossed_d = 1'b1;
          second_d  = 1'b1;
          st_d      = StPick;
        end else begin
          st_d = StOut;
        end
      end
      StOut: begin
        out_push_o = !out_full_i;
        if (!out_full_i) begin
          st_d = StIdle;
        end
      end
      default: begin
        st_d = StIdle;
      end
    endcase
  end

  // Control state and entry state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= StIdle;
      cur_q     <= '0;
      nxt_q     <= '0;
      fall_q    <= 1'b0;
      lfsr_q    <= LfsrSeed;
      second_q  <= 1'b0;
      crossed_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      cur_q     <= cur_d;
      nxt_q     <= nxt_d;
      fall_q    <= fall_d;
      lfsr_q    <= lfsr_d;
      second_q  <= second_d;
      crossed_q <= crossed_d;
    end
  end

  // Working item and datapath registers.
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    w_q    <= w_d;
    cs_q   <= cs_d;
    ns_q   <= ns_d;
    pa_q   <= pa_d;
    pb_q   <= pb_d;
  end

endmodule

>>> hw/rtl/lfo_driven_crossfade_selector_unit.sv
// Flow: an accepted input beat passes the front-end stages and the work queue, then
// the back-end states Prep, Mul and Out before its result enters the result queue;
// a next-entry pick adds the Pick state, and a random pick also waits on the remainder unit.
// The back end takes the next beat only after pushing the last result; the front end keeps accepting beats until full.
// Reset: rst_ni is asynchronous and active low; it empties both queues, clears the
// configuration and entry state and loads the LFSR seed.
module lfo_driven_crossfade_selector_unit #(
  parameter int unsigned QueueDepth = lcfs_pkg::QueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  lcfs_pkg::in_beat_t            in_beat_i,
  output logic                          empty,
  input  logic                          pop,
  output lcfs_pkg::out_beat_t           out_beat_o,
  input  logic                          cfg_we_i,
  input  logic [lcfs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lcfs_pkg::CfgDataW-1:0] cfg_data_i
);
  import lcfs_pkg::*;

  cfg_t      cfg_q;
  logic      wk_valid, wk_ready, wq_full, wq_empty, bk_pop;
  work_t     wk, wq_data;
  logic      oq_full, bk_push;
  out_beat_t bk_beat;

  assign wk_ready = !wq_full;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgCvRange: cfg_q.cv_range_mode <= cfg_data_i;
        CfgVoid:    cfg_q.void_mode     <= cfg_data_i[0];
        CfgReverse: cfg_q.reverse_mode  <= cfg_data_i[0];
        CfgRandom:  cfg_q.random_mode   <= cfg_data_i[0];
        default:    cfg_q <= cfg_q;
      endcase
    end
  end

  lcfs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .push_i       (push),
    .beat_i       (in_beat_i),
    .full_o       (full),
    .work_valid_o (wk_valid),
    .work_o       (wk),
    .work_ready_i (wk_ready)
  );

  // Queue between the front and back ends.
  lcfs_fifo #(
    .T     (work_t),
    .Depth (QueueDepth)
  ) u_work_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (wk_valid),
    .data_i  (wk),
    .full_o  (wq_full),
    .pop_i   (bk_pop),
    .data_o  (wq_data),
    .empty_o (wq_empty)
  );

  lcfs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .work_valid_i (!wq_empty),
    .work_i       (wq_data),
    .work_pop_o   (bk_pop),
    .out_full_i   (oq_full),
    .out_push_o   (bk_push),
    .out_beat_o   (bk_beat)
  );

  // Result queue toward the consumer.
  lcfs_fifo #(
    .T     (out_beat_t),
    .Depth (QueueDepth)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (bk_push),
    .data_i  (bk_beat),
    .full_o  (oq_full),
    .pop_i   (pop),
    .data_o  (out_beat_o),
    .empty_o (empty)
  );

endmodule

>>> hw/rtl/lcfs_checker.sv
// Port-level checker for the crossfade selector, bound to the top level below.
// Depends on lcfs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lcfs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                empty,
  input logic                pop,
  input lcfs_pkg::out_beat_t out_beat_o
);
  import lcfs_pkg::*;

  logic inactive_ok;

  // Fields that an inactive result must show as zero.
  assign inactive_ok = (out_beat_o.mix_out == '0) && (out_beat_o.current_weight == '0)
                       && (out_beat_o.current_slot == '0);

  // The result queue is empty at the edge after one where the reset is held.
  `LCFS_ASSERT_ALWAYS(a_empty_after_reset, clk_i, (!rst_ni |=> empty))

  // A waiting result beat stays put until it is taken.
  `LCFS_ASSERT(a_result_held, clk_i, rst_ni, (!empty && !pop |=> !empty && $stable(out_beat_o)))

  // An inactive result carries a zero mix, zero weight and slot zero.
  `LCFS_ASSERT(a_inactive_zero, clk_i, rst_ni, (!empty && !out_beat_o.active |-> inactive_ok))

  // The weight never exceeds one in Q16.
  `LCFS_ASSERT(a_weight_range, clk_i, rst_ni, (!empty |-> out_beat_o.current_weight <= QOne))

endmodule

bind lfo_driven_crossfade_selector_unit lcfs_checker u_lcfs_checker (.*);
